// ===== src/acir_pkg.sv =====
// ---------------------------------------------------------------------------
// acir_pkg: shared types and constants for the remote-control frame decoder
// frame geometry, header bytes, field positions and the result layout
// ---------------------------------------------------------------------------
package acir_pkg;

	localparam int FRAME_BYTES = 39;
	localparam int IDX_W       = 6;
	localparam int HDR_LEN     = 5;

	// byte positions inside the frame
	localparam logic [IDX_W-1:0] IDX_HDR_ONE = 6'd0;
	localparam logic [IDX_W-1:0] IDX_FIN     = 6'd12;
	localparam logic [IDX_W-1:0] IDX_OPT_A   = 6'd14;
	localparam logic [IDX_W-1:0] IDX_SUM_ONE = 6'd19;
	localparam logic [IDX_W-1:0] IDX_HDR_TWO = 6'd20;
	localparam logic [IDX_W-1:0] IDX_MODE    = 6'd25;
	localparam logic [IDX_W-1:0] IDX_TEMP    = 6'd26;
	localparam logic [IDX_W-1:0] IDX_AUTO    = 6'd27;
	localparam logic [IDX_W-1:0] IDX_FAN     = 6'd28;
	localparam logic [IDX_W-1:0] IDX_SWING   = 6'd29;
	localparam logic [IDX_W-1:0] IDX_OPT_B   = 6'd33;
	localparam logic [IDX_W-1:0] IDX_SUM_TWO = 6'd38;

	localparam logic [7:0] TEMP_WRAP   = 8'hD6;
	localparam logic [8:0] TEMP_OFS_HI = 9'h0E0;
	localparam logic [8:0] TEMP_OFS_LO = 9'h0C0;
	localparam logic [3:0] FAN_AUTO    = 4'hA;
	localparam logic [3:0] FAN_QUIET   = 4'hB;
	localparam logic [3:0] FAN_LVL_MIN = 4'h3;
	localparam logic [3:0] FAN_LVL_MAX = 4'h7;
	localparam logic [3:0] NIB_ALL     = 4'hF;

	// status codes
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_HDR_ONE = 3'd1;
	localparam logic [2:0] ST_HDR_TWO = 3'd2;
	localparam logic [2:0] ST_SUM_ONE = 3'd3;
	localparam logic [2:0] ST_SUM_TWO = 3'd4;

	// fan classes
	localparam logic [1:0] FAN_CLS_LEVEL   = 2'd0;
	localparam logic [1:0] FAN_CLS_AUTO    = 2'd1;
	localparam logic [1:0] FAN_CLS_QUIET   = 2'd2;
	localparam logic [1:0] FAN_CLS_UNKNOWN = 2'd3;

	localparam int OUT_W = 80;

	// result word, last field (status) in the lowest bits
	typedef struct packed {
		logic [3:0]             pad;
		logic [3:0]             option_flags;
		logic [1:0]             swing_bits;
		logic [1:0]             fan_class;
		logic [3:0]             fan_nibble;
		logic signed [8:0]      temp_half_deg;
		logic                   auto_temp;
		logic [3:0]             control_flags;
		logic [2:0]             op_mode;
		logic [3:0]             fin_angle;
		logic                   had_previous;
		logic [FRAME_BYTES-1:0] changed_mask;
		logic [2:0]             status;
	} result_t;

	// expected header bytes, second header differs only in the last byte
	function automatic logic [7:0] hdr_byte(input logic second, input logic [2:0] pos);
		logic [7:0] b;
		case (pos)
			3'd0: b = 8'h11;
			3'd1: b = 8'hDA;
			3'd2: b = 8'h27;
			3'd3: b = 8'h00;
			3'd4: b = second ? 8'h00 : 8'h02;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

// ===== src/ac_ir_frame_decoder.sv =====
// ---------------------------------------------------------------------------
// ac_ir_frame_decoder: 39-byte remote-control frame decoder
// byte-serial compare against the last full frame, header and sum checks,
// field extraction on the closing byte
// ---------------------------------------------------------------------------
//  channel | dir | width        | content
//  s_*     | in  | 8 + tlast    | frame bytes, tlast on the closing byte
//  m_*     | out | 80           | one decoded result per full-length frame
//
//  one byte per cycle sustained unless a decoded result waits on m_*; each byte is
//  registered into stage 1 and checked there, the result is registered in out_q for m_*
//  two banks of frame memory swap on each full frame; one read, one write
//  per cycle; reset clears control state only, memory needs no clearing
//  a stalled result stops the stage behind it and then s_tready
// ---------------------------------------------------------------------------
module ac_ir_frame_decoder (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [7:0]                s_tdata,   // [7:0] data_byte
	input  logic                      s_tlast,   // frame_end
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [acir_pkg::OUT_W-1:0] m_tdata   // status, changed_mask, had_previous,
	                                            // fin_angle, op_mode, control_flags,
	                                            // auto_temp, temp_half_deg, fan_nibble,
	                                            // fan_class, swing_bits, option_flags, pad
);
	import acir_pkg::*;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BYTES - 1);
	localparam logic [IDX_W-1:0] N_IDX    = IDX_W'(FRAME_BYTES);

	// two frame banks
	logic [7:0] mem_q [2][FRAME_BYTES];

	logic             accept;
	logic             in_range;
	logic [IDX_W-1:0] count_q;
	logic             ovf_q;
	logic             bank_q;
	logic             have_prev_q;

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic [7:0]       prev_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             inr_s1;
	logic             res_s1;
	logic             hadp_s1;
	logic             adv_s1;

	logic [FRAME_BYTES-1:0] mask_q, mask_nx;
	logic [7:0]             sum1_q, sum2_q;
	logic                   hdr1_q, hdr2_q, chk1_q;
	logic [7:0]             b12_q, b14_q, b25_q, b26_q, b27_q, b28_q, b29_q, b33_q;

	result_t res, out_q;
	logic    out_vld_q;

	assign in_range = count_q < N_IDX;
	assign adv_s1   = !(valid_s1 && res_s1 && out_vld_q && !m_tready);
	assign s_tready = !valid_s1 || adv_s1;
	assign accept   = s_tvalid && s_tready;

	// frame memory: write current bank, read the other one at the same index
	always_ff @(posedge clk) begin
		if (accept && in_range) begin
			mem_q[bank_q][count_q] <= s_tdata;
			prev_s1 <= mem_q[!bank_q][count_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			ovf_q       <= 1'b0;
			bank_q      <= 1'b0;
			have_prev_q <= 1'b0;
		end else if (accept) begin
			if (s_tlast) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
				// full frame: it becomes the previous frame
				if (count_q == LAST_IDX) begin
					bank_q      <= !bank_q;
					have_prev_q <= 1'b1;
				end
			end else if (in_range) begin
				count_q <= count_q + 1'b1;
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= s_tdata;
			idx_s1  <= count_q;
			inr_s1  <= in_range;
			res_s1  <= s_tlast && (count_q == LAST_IDX);
			hadp_s1 <= have_prev_q;
		end
	end

	always_comb begin
		mask_nx = (idx_s1 == '0) ? '0 : mask_q;
		if (hadp_s1 && inr_s1 && (prev_s1 != byte_s1))
			mask_nx[idx_s1] = 1'b1;
	end

	// running checks and field capture
	always_ff @(posedge clk) begin
		if (valid_s1 && adv_s1 && inr_s1) begin
			mask_q <= mask_nx;
			if (idx_s1 == IDX_HDR_ONE) begin
				sum1_q <= byte_s1;
				hdr1_q <= byte_s1 == hdr_byte(1'b0, 3'd0);
			end else if (idx_s1 < IDX_SUM_ONE) begin
				sum1_q <= sum1_q + byte_s1;
				if (idx_s1 < IDX_W'(HDR_LEN) && byte_s1 != hdr_byte(1'b0, idx_s1[2:0]))
					hdr1_q <= 1'b0;
			end
			if (idx_s1 == IDX_SUM_ONE)
				chk1_q <= sum1_q == byte_s1;
			if (idx_s1 == IDX_HDR_TWO) begin
				sum2_q <= byte_s1;
				hdr2_q <= byte_s1 == hdr_byte(1'b1, 3'd0);
			end else if (idx_s1 > IDX_HDR_TWO && idx_s1 < IDX_SUM_TWO) begin
				sum2_q <= sum2_q + byte_s1;
				if (idx_s1 < IDX_HDR_TWO + IDX_W'(HDR_LEN)
				    && byte_s1 != hdr_byte(1'b1, 3'(idx_s1 - IDX_HDR_TWO)))
					hdr2_q <= 1'b0;
			end
			if (idx_s1 == IDX_FIN)   b12_q <= byte_s1;
			if (idx_s1 == IDX_OPT_A) b14_q <= byte_s1;
			if (idx_s1 == IDX_MODE)  b25_q <= byte_s1;
			if (idx_s1 == IDX_TEMP)  b26_q <= byte_s1;
			if (idx_s1 == IDX_AUTO)  b27_q <= byte_s1;
			if (idx_s1 == IDX_FAN)   b28_q <= byte_s1;
			if (idx_s1 == IDX_SWING) b29_q <= byte_s1;
			if (idx_s1 == IDX_OPT_B) b33_q <= byte_s1;
		end
	end

	// result on the closing byte of a full frame
	always_comb begin
		res              = '0;
		res.changed_mask = mask_nx;
		res.had_previous = hadp_s1;
		if (!hdr1_q)
			res.status = ST_HDR_ONE;
		else if (!hdr2_q)
			res.status = ST_HDR_TWO;
		else if (!chk1_q)
			res.status = ST_SUM_ONE;
		else if (sum2_q != byte_s1)
			res.status = ST_SUM_TWO;
		else
			res.status = ST_OK;
		if (res.status == ST_OK) begin
			res.fin_angle     = b12_q[7:4];
			res.op_mode       = b25_q[6:4];
			res.control_flags = b25_q[3:0];
			res.auto_temp     = b27_q[7];
			if (!b27_q[7])
				res.temp_half_deg = {1'b0, b26_q};
			else if (b26_q >= TEMP_WRAP)
				res.temp_half_deg = {1'b0, b26_q} - TEMP_OFS_HI;
			else
				res.temp_half_deg = {1'b0, b26_q} - TEMP_OFS_LO;
			res.fan_nibble = b28_q[7:4];
			if (b28_q[7:4] >= FAN_LVL_MIN && b28_q[7:4] <= FAN_LVL_MAX)
				res.fan_class = FAN_CLS_LEVEL;
			else if (b28_q[7:4] == FAN_AUTO)
				res.fan_class = FAN_CLS_AUTO;
			else if (b28_q[7:4] == FAN_QUIET)
				res.fan_class = FAN_CLS_QUIET;
			else
				res.fan_class = FAN_CLS_UNKNOWN;
			res.swing_bits   = {b29_q[3:0] == NIB_ALL, b28_q[3:0] == NIB_ALL};
			res.option_flags = {b33_q[7], b33_q[2], b14_q[6], b14_q[4]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (valid_s1 && adv_s1 && res_s1) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv_s1 && res_s1)
			out_q <= res;
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_q;

endmodule
